### design/cpioscan_pkg.sv
// ----------------------------------------------------------------------------
// cpioscan_pkg
// Shared constants, codes and types of the cpio newc archive scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package cpioscan_pkg;

    // newc header layout
    localparam int HEADER_BYTES = 110;
    localparam int ALIGN_BYTES  = 4;
    localparam int ALIGN_BITS   = 2;
    localparam int FILESIZE_AT  = 54;
    localparam int NAMESIZE_AT  = 94;
    localparam int HEX_DIGITS   = 8;
    localparam int TRAILER_LEN  = 11;

    // result kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ENTRY = 2'd0;
    localparam kind_t KIND_NAME  = 2'd1;
    localparam kind_t KIND_DATA  = 2'd2;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_ARCHIVE_BASE = 2'd0;
    localparam cfg_index_t CFG_EMIT_NAMES   = 2'd1;
    localparam cfg_index_t CFG_EMIT_DATA    = 2'd2;

    // configuration as seen by the front and back parts
    typedef struct packed {
        logic [31:0] archive_base;
        logic        emit_names;
        logic        emit_data;
    } cfg_t;

    // one queued result, offsets still relative to the archive start
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_value;
        logic        is_padding;
        logic        final_name_byte;
        logic        is_trailer;
        logic [31:0] entry_start;
        logic [31:0] rel_data;
        logic [31:0] raw_size;
        logic [31:0] aligned_size;
        logic [31:0] name_size;
    } item_t;

    // end-of-archive name, terminating zero included
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h54; // T
            4'd1:    c = 8'h52; // R
            4'd2:    c = 8'h41; // A
            4'd3:    c = 8'h49; // I
            4'd4:    c = 8'h4C; // L
            4'd5:    c = 8'h45; // E
            4'd6:    c = 8'h52; // R
            4'd7:    c = 8'h21; // !
            4'd8:    c = 8'h21; // !
            4'd9:    c = 8'h21; // !
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### design/cpioscan_if.sv
// ----------------------------------------------------------------------------
// cpioscan channel interfaces
// Valid/ready channels for archive bytes, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// archive byte channel
interface cpioscan_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] archive_byte;

    modport source (output valid, output archive_byte, input ready);
    modport sink   (input valid, input archive_byte, output ready);
endinterface

// result channel
interface cpioscan_out_if;
    logic                valid;
    logic                ready;
    cpioscan_pkg::kind_t kind;
    logic [7:0]          byte_value;
    logic                is_padding;
    logic                final_name_byte;
    logic                is_trailer;
    logic [31:0]         entry_offset;
    logic [31:0]         data_offset;
    logic [31:0]         raw_size;
    logic [31:0]         aligned_size;
    logic [31:0]         name_size;

    modport source (output valid, output kind, output byte_value, output is_padding,
                    output final_name_byte, output is_trailer, output entry_offset,
                    output data_offset, output raw_size, output aligned_size,
                    output name_size, input ready);
    modport sink   (input valid, input kind, input byte_value, input is_padding,
                    input final_name_byte, input is_trailer, input entry_offset,
                    input data_offset, input raw_size, input aligned_size,
                    input name_size, output ready);
endinterface

// register write channel
interface cpioscan_cfg_if;
    logic                     valid;
    logic                     ready;
    cpioscan_pkg::cfg_index_t index;
    logic [31:0]              data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/cpio_newc_archive_scanner.sv
// ----------------------------------------------------------------------------
// cpio_newc_archive_scanner
// Streaming scanner for cpio newc archives with entry, name and data results.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one archive byte per beat, starting at the first header.
//   out_ch carries results: an entry record at the last byte of each header,
//          name bytes when emit_names is set, data bytes (padding included,
//          flagged) when emit_data is set.
//   cfg_ch writes archive_base (0), emit_names (1), emit_data (2); always
//          ready; the user must write only while no result is outstanding,
//          which the block does not enforce. One byte is taken every cycle
//   while the queue is not full. A result passes through the result queue
//   and the output register. The parser advances one phase step per byte.
//   When out_ch stalls, the queue (QUEUE_DEPTH entries) fills and in_ch
//   drops ready; bytes that cause no result still need a free slot.
//   Reset returns the parser to the start of a header at offset zero with
//   emit_names set, emit_data clear and a zero base. After the trailer
//   entry, all bytes are taken and dropped until the next reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cpio_newc_archive_scanner #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    cpioscan_in_if.sink     in_ch,
    cpioscan_out_if.source  out_ch,
    cpioscan_cfg_if.sink    cfg_ch
);

    logic [31:0]         base_reg;
    logic                emit_names_reg;
    logic                emit_data_reg;
    cpioscan_pkg::cfg_t  cfg;
    logic                q_push;
    cpioscan_pkg::item_t q_push_item;
    logic                q_pop;
    logic                q_full;
    logic                q_not_empty;
    cpioscan_pkg::item_t q_head;

    // register writes
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= 32'd0;
            emit_names_reg <= 1'b1;
            emit_data_reg  <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                cpioscan_pkg::CFG_ARCHIVE_BASE: base_reg       <= cfg_ch.data;
                cpioscan_pkg::CFG_EMIT_NAMES:   emit_names_reg <= cfg_ch.data[0];
                cpioscan_pkg::CFG_EMIT_DATA:    emit_data_reg  <= cfg_ch.data[0];
                default:                        base_reg       <= base_reg;
            endcase
        end
    end

    assign cfg.archive_base = base_reg;
    assign cfg.emit_names   = emit_names_reg;
    assign cfg.emit_data    = emit_data_reg;

    // parser
    cpioscan_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (q_push),
        .push_item (q_push_item)
    );

    // result queue
    cpioscan_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // output stage
    cpioscan_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (q_pop),
        .out_ch      (out_ch)
    );

endmodule

`default_nettype wire

### design/cpioscan_front.sv
// ----------------------------------------------------------------------------
// cpioscan_front
// Byte parser: tracks header, name, padding and data phases and queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module cpioscan_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    cpioscan_in_if.sink              in_ch,
    input  wire cpioscan_pkg::cfg_t  cfg,
    input  wire logic                q_full,
    output logic                     push,
    output cpioscan_pkg::item_t      push_item
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_PAD    = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [31:0] HDR_LAST   = 32'(cpioscan_pkg::HEADER_BYTES - 1);
    localparam logic [31:0] FS_FIRST   = 32'(cpioscan_pkg::FILESIZE_AT);
    localparam logic [31:0] FS_END     = 32'(cpioscan_pkg::FILESIZE_AT
                                             + cpioscan_pkg::HEX_DIGITS);
    localparam logic [31:0] NS_FIRST   = 32'(cpioscan_pkg::NAMESIZE_AT);
    localparam logic [31:0] NS_END     = 32'(cpioscan_pkg::NAMESIZE_AT
                                             + cpioscan_pkg::HEX_DIGITS);
    localparam logic [31:0] TRL_LEN    = 32'(cpioscan_pkg::TRAILER_LEN);
    localparam logic [31:0] ALIGN_ADD  = 32'(cpioscan_pkg::ALIGN_BYTES - 1);
    localparam logic [31:0] ALIGN_MASK = ~ALIGN_ADD;
    localparam logic [31:0] HN_ADD     = 32'(cpioscan_pkg::HEADER_BYTES
                                             + cpioscan_pkg::ALIGN_BYTES - 1);
    localparam logic [cpioscan_pkg::ALIGN_BITS-1:0] HDR_LOW =
        cpioscan_pkg::ALIGN_BITS'(cpioscan_pkg::HEADER_BYTES);

    // hex character to nibble, anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = c[3:0];
        else if (c >= 8'h41 && c <= 8'h46)
            v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 4'(c - 8'h57);
        else
            v = 4'd0;
        return v;
    endfunction

    logic [2:0]  phase_reg,       phase_next;
    logic [31:0] position_reg,    position_next;
    logic [31:0] name_size_reg,   name_size_next;
    logic [31:0] raw_size_reg,    raw_size_next;
    logic [31:0] entry_start_reg, entry_start_next;
    logic [31:0] stream_off_reg;
    logic        trl_match_reg,   trl_match_next;

    // sums derived from the parsed sizes, settled long before the last header beat
    logic [31:0] fs_al_reg;
    logic [31:0] hn_al_reg;
    logic [31:0] rel_data_reg;

    logic        fire;
    logic [7:0]  b;
    logic [3:0]  nib;
    logic [cpioscan_pkg::ALIGN_BITS-1:0] hn_low;
    logic [cpioscan_pkg::ALIGN_BITS-1:0] pad_cnt;
    logic [2:0]  enter_data_ph;
    logic [2:0]  enter_pad_ph;
    logic [2:0]  enter_name_ph;
    logic        name_last;
    logic        name_mismatch;
    logic        match_now;
    logic        trailer_hit;

    assign in_ch.ready = !q_full;
    assign fire        = in_ch.valid && in_ch.ready;
    assign b           = in_ch.archive_byte;
    assign nib         = hex_nibble(b);

    // skipping of empty phases
    assign hn_low        = name_size_reg[cpioscan_pkg::ALIGN_BITS-1:0] + HDR_LOW;
    assign pad_cnt       = '0 - hn_low;
    assign enter_data_ph = (fs_al_reg == 32'd0) ? PH_HEADER : PH_DATA;
    assign enter_pad_ph  = (pad_cnt == '0) ? enter_data_ph : PH_PAD;
    assign enter_name_ph = (name_size_reg == 32'd0) ? enter_pad_ph : PH_NAME;

    // name compare against the trailer
    assign name_last     = (position_reg == name_size_reg - 32'd1);
    assign name_mismatch = (position_reg < TRL_LEN)
                           && (b != cpioscan_pkg::trailer_char(position_reg[3:0]));
    assign match_now     = trl_match_reg && !name_mismatch;
    assign trailer_hit   = name_last && match_now && (name_size_reg >= TRL_LEN);

    // phase walk for one accepted beat
    always_comb
    begin
        phase_next       = phase_reg;
        position_next    = position_reg;
        name_size_next   = name_size_reg;
        raw_size_next    = raw_size_reg;
        entry_start_next = entry_start_reg;
        trl_match_next   = trl_match_reg;
        push             = 1'b0;
        push_item        = '0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (position_reg == 32'd0)
                    begin
                        entry_start_next = stream_off_reg;
                        trl_match_next   = 1'b1;
                    end
                    if (position_reg >= FS_FIRST && position_reg < FS_END)
                        raw_size_next = {raw_size_reg[27:0], nib};
                    if (position_reg >= NS_FIRST && position_reg < NS_END)
                        name_size_next = {name_size_reg[27:0], nib};
                    if (position_reg == HDR_LAST)
                    begin
                        push                   = 1'b1;
                        push_item.kind         = cpioscan_pkg::KIND_ENTRY;
                        push_item.entry_start  = entry_start_reg;
                        push_item.rel_data     = rel_data_reg;
                        push_item.raw_size     = raw_size_reg;
                        push_item.aligned_size = fs_al_reg;
                        push_item.name_size    = name_size_reg;
                        phase_next             = enter_name_ph;
                        position_next          = 32'd0;
                    end
                    else
                    begin
                        position_next = position_reg + 32'd1;
                    end
                end
                PH_NAME:
                begin
                    trl_match_next = match_now;
                    if (cfg.emit_names)
                    begin
                        push                      = 1'b1;
                        push_item.kind            = cpioscan_pkg::KIND_NAME;
                        push_item.byte_value      = b;
                        push_item.final_name_byte = name_last;
                        push_item.is_trailer      = trailer_hit;
                    end
                    if (name_last)
                    begin
                        phase_next    = trailer_hit ? PH_DONE : enter_pad_ph;
                        position_next = 32'd0;
                    end
                    else
                    begin
                        position_next = position_reg + 32'd1;
                    end
                end
                PH_PAD:
                begin
                    if (position_reg[cpioscan_pkg::ALIGN_BITS-1:0] == pad_cnt - 1'b1)
                    begin
                        phase_next    = enter_data_ph;
                        position_next = 32'd0;
                    end
                    else
                    begin
                        position_next = position_reg + 32'd1;
                    end
                end
                PH_DATA:
                begin
                    if (cfg.emit_data)
                    begin
                        push                 = 1'b1;
                        push_item.kind       = cpioscan_pkg::KIND_DATA;
                        push_item.byte_value = b;
                        push_item.is_padding = (position_reg >= raw_size_reg);
                    end
                    if (position_reg == fs_al_reg - 32'd1)
                    begin
                        phase_next    = PH_HEADER;
                        position_next = 32'd0;
                    end
                    else
                    begin
                        position_next = position_reg + 32'd1;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            position_reg    <= 32'd0;
            name_size_reg   <= 32'd0;
            raw_size_reg    <= 32'd0;
            entry_start_reg <= 32'd0;
            stream_off_reg  <= 32'd0;
            trl_match_reg   <= 1'b1;
        end
        else
        begin
            phase_reg       <= phase_next;
            position_reg    <= position_next;
            name_size_reg   <= name_size_next;
            raw_size_reg    <= raw_size_next;
            entry_start_reg <= entry_start_next;
            trl_match_reg   <= trl_match_next;
            if (fire)
                stream_off_reg <= stream_off_reg + 32'd1;
        end
    end

    // aligned sizes and relative data offset, recomputed every cycle
    always_ff @(posedge clk)
    begin
        fs_al_reg    <= (raw_size_reg + ALIGN_ADD) & ALIGN_MASK;
        hn_al_reg    <= (name_size_reg + HN_ADD) & ALIGN_MASK;
        rel_data_reg <= entry_start_reg + hn_al_reg;
    end

endmodule

`default_nettype wire

### design/cpioscan_queue.sv
// ----------------------------------------------------------------------------
// cpioscan_queue
// Short register queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpioscan_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire cpioscan_pkg::item_t push_item,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output cpioscan_pkg::item_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    cpioscan_pkg::item_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### design/cpioscan_back.sv
// ----------------------------------------------------------------------------
// cpioscan_back
// Output stage: adds the archive base to offsets and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cpioscan_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cpioscan_pkg::cfg_t  cfg,
    input  wire logic                q_not_empty,
    input  wire cpioscan_pkg::item_t q_head,
    output logic                     pop,
    cpioscan_out_if.source           out_ch
);

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic        pad_reg;
    logic        final_reg;
    logic        trailer_reg;
    logic [31:0] entry_off_reg;
    logic [31:0] data_off_reg;
    logic [31:0] fsize_reg;
    logic [31:0] fsize_al_reg;
    logic [31:0] nsize_reg;
    logic        is_entry;

    assign pop      = q_not_empty && (!valid_reg || out_ch.ready);
    assign is_entry = (q_head.kind == cpioscan_pkg::KIND_ENTRY);

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ch.ready)
            valid_reg <= 1'b0;
    end

    // output payload, offsets only carried by entry records
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg      <= q_head.kind;
            byte_reg      <= q_head.byte_value;
            pad_reg       <= q_head.is_padding;
            final_reg     <= q_head.final_name_byte;
            trailer_reg   <= q_head.is_trailer;
            entry_off_reg <= is_entry ? cfg.archive_base + q_head.entry_start : 32'd0;
            data_off_reg  <= is_entry ? cfg.archive_base + q_head.rel_data : 32'd0;
            fsize_reg     <= q_head.raw_size;
            fsize_al_reg  <= q_head.aligned_size;
            nsize_reg     <= q_head.name_size;
        end
    end

    assign out_ch.valid           = valid_reg;
    assign out_ch.kind            = kind_reg;
    assign out_ch.byte_value      = byte_reg;
    assign out_ch.is_padding      = pad_reg;
    assign out_ch.final_name_byte = final_reg;
    assign out_ch.is_trailer      = trailer_reg;
    assign out_ch.entry_offset    = entry_off_reg;
    assign out_ch.data_offset     = data_off_reg;
    assign out_ch.raw_size        = fsize_reg;
    assign out_ch.aligned_size    = fsize_al_reg;
    assign out_ch.name_size       = nsize_reg;

endmodule

`default_nettype wire
